// ===== design/ufmt_pkg.sv =====
package ufmt_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 4;
    localparam int CNT_W      = 7;
    localparam int FLAG_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 64;
    localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]   MAX_FIELD = 7'd64;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 4'd8;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_SPACE  = 8'h20;

    // flag bit positions
    localparam int FLAG_ALT  = 0;
    localparam int FLAG_ZPAD = 1;
    localparam int FLAG_LEFT = 2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [CNT_W-1:0]   field_width;
        logic [CNT_W-1:0]   precision;
        logic [FLAG_W-1:0]  flag_bits;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } res_t;

    // one formatted run: region boundaries and digits, most significant on top
    typedef struct packed {
        logic [CNT_W-1:0]    pad_end;
        logic [CNT_W-1:0]    zero_end;
        logic [CNT_W-1:0]    digit_end;
        logic [CNT_W-1:0]    total;
        logic [DIGITS_W-1:0] digits;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

endpackage

// ===== design/ufmt_digits.sv =====
module ufmt_digits (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          shift_en,
    input  logic                          bit_in,
    input  logic [ufmt_pkg::RADIX_W-1:0]  radix,
    output logic [ufmt_pkg::DIGITS_W-1:0] digits,
    output logic [ufmt_pkg::CNT_W-1:0]    len
);
    import ufmt_pkg::*;

    localparam int LEVELS = $clog2(NUM_DIGITS);

    logic [DIGIT_W-1:0]    cell_reg [NUM_DIGITS];
    logic [DIGIT_W-1:0]    cell_next [NUM_DIGITS];
    logic [DIGIT_W:0]      sum [NUM_DIGITS];
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [NUM_DIGITS-1:0] gen, prop, carry, cin_vec;
    logic [NUM_DIGITS-1:0] g_lvl [LEVELS+1];
    logic [NUM_DIGITS-1:0] p_lvl [LEVELS+1];
    logic [LEVELS-1:0]     top_idx;

    // Each cell doubles its base-r digit and adds the carry from below.
    // Carries resolve through a prefix tree: generate when 2d >= r,
    // propagate when 2d + 1 == r.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            gen[i]  = {cell_reg[i], 1'b0} >= {1'b0, radix};
            prop[i] = {cell_reg[i], 1'b1} == {1'b0, radix};
        end
        g_lvl[0] = gen;
        p_lvl[0] = prop;
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (i >= (1 << l))
                begin
                    g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i-(1<<l)]);
                    p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i-(1<<l)];
                end
                else
                begin
                    g_lvl[l+1][i] = g_lvl[l][i];
                    p_lvl[l+1][i] = p_lvl[l][i];
                end
            end
        end
        carry   = g_lvl[LEVELS] | (p_lvl[LEVELS] & {NUM_DIGITS{bit_in}});
        cin_vec = {carry[NUM_DIGITS-2:0], bit_in};
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            sum[i]       = {cell_reg[i], cin_vec[i]};
            cell_next[i] = carry[i] ? DIGIT_W'(sum[i] - {1'b0, radix})
                                    : DIGIT_W'(sum[i]);
        end
    end

    // a new top digit can only appear by a carry out of the current top one
    assign top_idx = LEVELS'(len_reg - 1'b1);

    always_comb
    begin
        len_next = len_reg;
        if (clear)
            len_next = CNT_W'(1);
        else if (shift_en && len_reg != CNT_W'(NUM_DIGITS) && carry[top_idx])
            len_next = len_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= CNT_W'(1);
        else
            len_reg <= len_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (clear)
                cell_reg[i] <= '0;
            else if (shift_en)
                cell_reg[i] <= cell_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
            digits[i*DIGIT_W +: DIGIT_W] = cell_reg[i];
    end

    assign len = len_reg;

endmodule

// ===== design/ufmt_front.sv =====
module ufmt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ufmt_pkg::cmd_t       cmd,
    output ufmt_pkg::job_t       job,
    output logic                 push,
    input  logic                 full
);
    import ufmt_pkg::*;

    front_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]    value_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [CNT_W-1:0]      fw_reg, pr_reg;
    logic [FLAG_W-1:0]     flags_reg;
    logic                  nz_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                  accept, shift_en, conv_done;
    logic [DIGITS_W-1:0]   digits;
    logic [CNT_W-1:0]      len;
    logic [CNT_W-1:0]      mx0, mx, mn, total, gap, lead, zeros, zero_end;
    logic [BIT_CNT_W-1:0]  align;
    logic                  oct_bump, zp;

    assign accept    = start && !busy;
    assign conv_done = bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (start) state_next = F_CONV;
            F_CONV:  if (conv_done) state_next = F_PUSH;
            F_PUSH:  if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        shift_en = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            F_IDLE:  busy = 1'b0;
            F_CONV:  shift_en = 1'b1;
            F_PUSH:  push = !full;
            default: busy = 1'b1;
        endcase
    end

    assign bit_cnt_next = accept ? '0 : (shift_en ? bit_cnt_reg + 1'b1 : bit_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= cmd.value;
            if (cmd.radix < RADIX_MIN)
                radix_reg <= RADIX_MIN;
            else if (cmd.radix > RADIX_MAX)
                radix_reg <= RADIX_MAX;
            else
                radix_reg <= cmd.radix;
            fw_reg    <= (cmd.field_width > MAX_FIELD) ? MAX_FIELD : cmd.field_width;
            pr_reg    <= (cmd.precision > MAX_FIELD) ? MAX_FIELD : cmd.precision;
            flags_reg <= cmd.flag_bits;
            nz_reg    <= cmd.value != '0;
        end
        else if (shift_en)
        begin
            value_reg <= {value_reg[VALUE_W-2:0], 1'b0};
        end
    end

    ufmt_digits u_digits (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .shift_en (shift_en),
        .bit_in   (value_reg[VALUE_W-1]),
        .radix    (radix_reg),
        .digits   (digits),
        .len      (len)
    );

    // run layout: lead spaces | zeros | digits | trailing spaces
    always_comb
    begin
        mx0      = (pr_reg > len) ? pr_reg : len;
        oct_bump = flags_reg[FLAG_ALT] && radix_reg == RADIX_OCT && mx0 == len && nz_reg;
        mx       = mx0 + CNT_W'(oct_bump);
        mn       = (fw_reg > len) ? fw_reg : len;
        total    = (mx > mn) ? mx : mn;
        zp       = flags_reg[FLAG_ZPAD] && pr_reg == '0;
        gap      = (mn > mx) ? mn - mx : '0;
        lead     = (!zp && !flags_reg[FLAG_LEFT]) ? gap : '0;
        zeros    = zp ? total - len : mx - len;
        zero_end = lead + zeros;
        align    = BIT_CNT_W'(CNT_W'(NUM_DIGITS) - len);

        job.pad_end   = lead;
        job.zero_end  = zero_end;
        job.digit_end = zero_end + len;
        job.total     = total;
        job.digits    = digits << {align, 2'b00};
    end

endmodule

// ===== design/ufmt_queue.sv =====
module ufmt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ufmt_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output ufmt_pkg::job_t rd_job,
    output logic           empty
);
    import ufmt_pkg::*;

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      count_reg, count_next;

    assign full   = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'((wr_ptr_reg + 1'b1) % QUEUE_DEPTH);
            if (pop)
                rd_ptr_reg <= QPTR_W'((rd_ptr_reg + 1'b1) % QUEUE_DEPTH);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== design/ufmt_back.sv =====
module ufmt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ufmt_pkg::job_t job,
    input  logic           empty,
    output logic           pop,
    output ufmt_pkg::res_t res,
    output logic           res_strobe
);
    import ufmt_pkg::*;

    back_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pad_end_reg, zero_end_reg, digit_end_reg, total_reg;
    logic [DIGITS_W-1:0]  digits_reg;
    res_t                 res_reg, res_next;
    logic                 strobe_reg, strobe_next;
    logic                 emit, in_digits, is_last;
    logic [DIGIT_W-1:0]   top_digit;

    assign is_last = (idx_reg + 1'b1) == total_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!empty) state_next = B_RUN;
            B_RUN:   if (is_last) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop = !empty;
            B_RUN:   emit = 1'b1;
            default: pop = 1'b0;
        endcase
    end

    assign top_digit = digits_reg[DIGITS_W-1 -: DIGIT_W];
    assign in_digits = idx_reg >= zero_end_reg && idx_reg < digit_end_reg;

    always_comb
    begin
        if (idx_reg < pad_end_reg)
            res_next.character = CH_SPACE;
        else if (idx_reg < zero_end_reg)
            res_next.character = CH_ZERO;
        else if (in_digits)
            res_next.character = CH_ZERO + CHAR_W'(top_digit);
        else
            res_next.character = CH_SPACE;
        res_next.last = is_last;
        strobe_next   = emit;
        idx_next      = pop ? '0 : (emit ? idx_reg + 1'b1 : idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (pop)
        begin
            pad_end_reg   <= job.pad_end;
            zero_end_reg  <= job.zero_end;
            digit_end_reg <= job.digit_end;
            total_reg     <= job.total;
            digits_reg    <= job.digits;
        end
        else if (emit && in_digits)
        begin
            digits_reg <= {digits_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    assign res        = res_reg;
    assign res_strobe = strobe_reg;

endmodule

// ===== design/unsigned_integer_text_formatter_core.sv =====
// Channel   | Ports                 | Handshake
// ----------+-----------------------+------------------------------------------
// command   | start, busy, cmd      | item taken on clk edge with start && !busy
// result    | res_strobe, res       | one character per strobe cycle, no stall
//
// Conversion shifts the 64-bit value in one bit per cycle through a row of
// base-r digit cells, then hands the run to the queue, waiting while it is
// full. The emitter loads a run and then sends one character per cycle,
// 1 to 64 per item. A two-entry queue lets conversion of the next item
// overlap emission.
// Reset clears all control state; no clearing pass is needed.
module unsigned_integer_text_formatter_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ufmt_pkg::cmd_t cmd,
    output logic           res_strobe,
    output ufmt_pkg::res_t res
);
    import ufmt_pkg::*;

    job_t front_job, head_job;
    logic push, full, pop, empty;

    ufmt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .job   (front_job),
        .push  (push),
        .full  (full)
    );

    ufmt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .full   (full),
        .pop    (pop),
        .rd_job (head_job),
        .empty  (empty)
    );

    ufmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .empty      (empty),
        .pop        (pop),
        .res        (res),
        .res_strobe (res_strobe)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import ufmt_pkg::*;

    localparam int          RANDOM_ITEMS = 390;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          MAX_GAP      = 120;

    localparam logic [FLAG_W-1:0] FL_NONE = '0;
    localparam logic [FLAG_W-1:0] FL_ALT  = FLAG_W'(1) << FLAG_ALT;
    localparam logic [FLAG_W-1:0] FL_ZPAD = FLAG_W'(1) << FLAG_ZPAD;
    localparam logic [FLAG_W-1:0] FL_LEFT = FLAG_W'(1) << FLAG_LEFT;

    typedef struct {
        cmd_t  cmd;
        string text;   // empty: take the text from format_text
    } row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic res_strobe;
    res_t res;

    res_t pending_chars[$];
    row_t directed_rows[$];
    int   error_count = 0;

    unsigned_integer_text_formatter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .res_strobe (res_strobe),
        .res        (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Text that one item should produce, one byte per character.
    function automatic string format_text(cmd_t c);
        logic [VALUE_W-1:0] t;
        logic [DIGIT_W-1:0] dig [NUM_DIGITS];
        int unsigned r, fw, pr, len, mx, mn, total, lead, zeros, trail, i;
        bit zp;
        string s;
        r = c.radix;
        if (r < RADIX_MIN) r = RADIX_MIN;
        if (r > RADIX_MAX) r = RADIX_MAX;
        fw = (c.field_width > MAX_FIELD) ? MAX_FIELD : c.field_width;
        pr = (c.precision > MAX_FIELD) ? MAX_FIELD : c.precision;
        t = c.value;
        len = 0;
        do
        begin
            dig[len] = DIGIT_W'(t % r);
            t = t / r;
            len++;
        end while (t != 0 && len < NUM_DIGITS);
        mx = (pr > len) ? pr : len;
        mn = (fw > len) ? fw : len;
        // octal alternate form wants a leading zero unless one is already there
        if (c.flag_bits[FLAG_ALT] && r == RADIX_OCT && mx == len && c.value != 0)
            mx++;
        total = (mx > mn) ? mx : mn;
        zp = c.flag_bits[FLAG_ZPAD] && pr == 0;
        lead  = (!zp && !c.flag_bits[FLAG_LEFT] && mn > mx) ? mn - mx : 0;
        trail = (!zp &&  c.flag_bits[FLAG_LEFT] && mn > mx) ? mn - mx : 0;
        zeros = zp ? total - len : mx - len;
        s = "";
        for (i = 0; i < lead && s.len() < NUM_DIGITS; i++)
            s = $sformatf("%s%c", s, CH_SPACE);
        for (i = 0; i < zeros && s.len() < NUM_DIGITS; i++)
            s = $sformatf("%s%c", s, CH_ZERO);
        for (i = len; i > 0 && s.len() < NUM_DIGITS; i--)
            s = $sformatf("%s%c", s, CH_ZERO + CHAR_W'(dig[i-1]));
        for (i = 0; i < trail && s.len() < NUM_DIGITS; i++)
            s = $sformatf("%s%c", s, CH_SPACE);
        return s;
    endfunction

    function automatic void expect_text(string s);
        res_t want;
        for (int i = 0; i < s.len(); i++)
        begin
            want.character = s[i];
            want.last = (i == s.len() - 1);
            pending_chars.push_back(want);
        end
    endfunction

    function automatic void add_row(logic [VALUE_W-1:0] v, int r, int fw, int pr,
                                    logic [FLAG_W-1:0] fl, string text);
        row_t row;
        row.cmd.value       = v;
        row.cmd.radix       = RADIX_W'(r);
        row.cmd.field_width = CNT_W'(fw);
        row.cmd.precision   = CNT_W'(pr);
        row.cmd.flag_bits   = fl;
        row.text = text;
        directed_rows.push_back(row);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   shift;
        c.value = {$urandom, $urandom};
        shift = $urandom_range(0, 63);
        case ($urandom_range(0, 3))
            0: ;
            1: c.value = c.value >> shift;
            2: c.value = VALUE_W'($urandom_range(0, 20));
            default: c.value = {VALUE_W{1'b1}} >> shift;
        endcase
        if ($urandom_range(0, 9) != 0)
            c.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        else
            c.radix = RADIX_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       c.field_width = CNT_W'($urandom_range(0, 127));
            1, 2:    c.field_width = CNT_W'($urandom_range(0, MAX_FIELD));
            default: c.field_width = CNT_W'($urandom_range(0, 12));
        endcase
        case ($urandom_range(0, 19))
            0:          c.precision = CNT_W'($urandom_range(0, 127));
            1, 2, 3:    c.precision = CNT_W'($urandom_range(0, MAX_FIELD));
            4, 5, 6, 7,
            8, 9:       c.precision = CNT_W'($urandom_range(0, 12));
            default:    c.precision = '0;
        endcase
        c.flag_bits = FLAG_W'($urandom_range(0, 7));
        return c;
    endfunction

    // Hold the item on the port until the block takes it.
    task automatic send(cmd_t c, string text);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        expect_text(text);
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
    endtask

    always @(posedge clk)
    begin : char_check
        res_t want;
        if (rst_n && res_strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character %h last %b", res.character, res.last);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (res.character !== want.character)
                begin
                    $error("character: expected %h, got %h", want.character, res.character);
                    error_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, res.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        cmd_t c;
        string text;

        add_row('0, RADIX_MAX, 0, 0, FL_NONE, "0");
        add_row('1, RADIX_MAX, 0, 0, FL_NONE, "18446744073709551615");
        add_row('1, RADIX_MIN, 0, 0, FL_NONE, "");
        add_row('0, RADIX_OCT, 0, 0, FL_ALT, "0");
        add_row(8, RADIX_OCT, 0, 0, FL_ALT, "010");
        add_row(8, RADIX_OCT, 0, 3, FL_ALT, "");
        add_row(8, RADIX_OCT, 6, 0, FL_ALT | FL_ZPAD, "");
        add_row('1, RADIX_OCT, 0, 0, FL_ALT, "");
        add_row(5, RADIX_MAX, 4, 0, FL_ZPAD, "0005");
        add_row(5, RADIX_MAX, 4, 2, FL_ZPAD, "  05");
        add_row(5, RADIX_MAX, 4, 0, FL_ZPAD | FL_LEFT, "0005");
        add_row(5, RADIX_MAX, 4, 0, FL_LEFT, "5   ");
        add_row(5, RADIX_MAX, 4, 0, FL_NONE, "   5");
        add_row(1, RADIX_MAX, 127, 0, FL_NONE, "");
        add_row(1, RADIX_MAX, 0, 127, FL_NONE, "");
        add_row(77, 9, 64, 64, FL_LEFT, "");
        add_row(5, 0, 0, 0, FL_NONE, "101");
        add_row(5, 1, 0, 0, FL_NONE, "101");
        add_row(255, 15, 0, 0, FL_NONE, "255");
        add_row(255, 11, 0, 0, FL_NONE, "255");
        add_row('0, RADIX_OCT, 64, 0, FL_ALT | FL_ZPAD | FL_LEFT, "");
        add_row('1, 3, 64, 64, FL_ALT | FL_ZPAD | FL_LEFT, "");
        add_row('0, RADIX_MAX, 0, 0, FL_ALT | FL_LEFT, "");
        add_row(64'h8000_0000_0000_0000, RADIX_MIN, 10, 0, FL_ZPAD, "");

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            text = (directed_rows[i].text != "") ? directed_rows[i].text
                                                 : format_text(directed_rows[i].cmd);
            send(directed_rows[i].cmd, text);
            maybe_idle(1'b0);
        end
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            c = random_cmd();
            send(c, format_text(c));
            if (n == 60 || n == 300)
                wait_for_drain();
            else
                maybe_idle(n >= 150 && n < 250);
        end

        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
